FILE: design/indexed_shift_list_assert.svh
// ----------------------------------------------------------------------------
// indexed_shift_list assertion macros
// shared property forms for the checker, clocked on i_clk, off in reset
// ----------------------------------------------------------------------------
`ifndef INDEXED_SHIFT_LIST_ASSERT_SVH
`define INDEXED_SHIFT_LIST_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define ISL_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("indexed_shift_list check failed");

// consequent must hold in the cycle after the antecedent
`define ISL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("indexed_shift_list check failed");

`endif

FILE: design/isl_pkg.sv
// ----------------------------------------------------------------------------
// isl_pkg
// types and codes shared by the indexed shift list modules
// ----------------------------------------------------------------------------
package isl_pkg;

    typedef logic signed [31:0] t_word;

    // one command transfer
    typedef struct packed {
        logic [3:0]  func;
        logic [6:0]  index;
        t_word       value;
    } t_in;

    // one result transfer
    typedef struct packed {
        t_word       data;
        logic [6:0]  count;
        logic [1:0]  status;
    } t_out;

    // operation codes
    localparam logic [3:0] FUNC_READ       = 4'd0;
    localparam logic [3:0] FUNC_WRITE      = 4'd1;
    localparam logic [3:0] FUNC_PUSH_BACK  = 4'd2;
    localparam logic [3:0] FUNC_PUSH_FRONT = 4'd3;
    localparam logic [3:0] FUNC_POP_BACK   = 4'd4;
    localparam logic [3:0] FUNC_POP_FRONT  = 4'd5;
    localparam logic [3:0] FUNC_INSERT     = 4'd6;
    localparam logic [3:0] FUNC_REMOVE     = 4'd7;
    localparam logic [3:0] FUNC_CLEAR      = 4'd8;
    localparam logic [3:0] FUNC_FRONT      = 4'd9;
    localparam logic [3:0] FUNC_BACK       = 4'd10;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam t_word BAD_READ_WORD = -32'sd1;

    // cells per registered group of the read-out tree
    localparam int TREE_GRP = 16;

    // what each cell does this cycle
    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_WRITE = 2'd1,
        CELL_INS   = 2'd2,
        CELL_DEL   = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     tap_en;
    } t_cell_ctl;

endpackage

FILE: design/isl_cell.sv
// ----------------------------------------------------------------------------
// isl_cell
// one list position: holds a word, takes a neighbor's word on insert/remove
// ----------------------------------------------------------------------------
module isl_cell import isl_pkg::*; #(
    parameter int IDX_W    = 6,
    parameter int CELL_POS = 0
) (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [IDX_W-1:0] i_pos,
    input  logic [IDX_W-1:0] i_sel,
    input  t_word            i_value,
    input  t_word            i_prev,
    input  t_word            i_next,
    output t_word            o_word,
    output t_word            o_tap
);

    localparam logic [IDX_W-1:0] MY_POS = IDX_W'(CELL_POS);

    t_word r_word;
    t_word n_word;
    t_word r_tap;

    // next word from the broadcast operation
    always_comb begin
        n_word = r_word;
        case (i_ctl.op)
            CELL_WRITE: begin
                if (MY_POS == i_pos) n_word = i_value;
            end
            CELL_INS: begin
                if (MY_POS > i_pos) n_word = i_prev;
                else if (MY_POS == i_pos) n_word = i_value;
            end
            CELL_DEL: begin
                if (MY_POS >= i_pos) n_word = i_next;
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    // word storage and read tap
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_tap  <= (i_ctl.tap_en && (MY_POS == i_sel)) ? r_word : '0;
    end

    assign o_word = r_word;
    assign o_tap  = r_tap;

endmodule

FILE: design/isl_or_tree.sv
// ----------------------------------------------------------------------------
// isl_or_tree
// gathers the one selected cell tap through a registered two-level or tree
// ----------------------------------------------------------------------------
module isl_or_tree import isl_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic  i_clk,
    input  t_word i_taps [CAPACITY],
    output t_word o_word
);

    localparam int NGRP = (CAPACITY + TREE_GRP - 1) / TREE_GRP;

    t_word part  [NGRP][TREE_GRP];
    t_word n_grp [NGRP];
    t_word r_grp [NGRP];
    t_word sum;

    // spread taps into groups, padding the last one
    for (genvar g = 0; g < NGRP; g++) begin : g_grp
        for (genvar k = 0; k < TREE_GRP; k++) begin : g_leaf
            if (g * TREE_GRP + k < CAPACITY) begin : g_used
                assign part[g][k] = i_taps[g * TREE_GRP + k];
            end else begin : g_pad
                assign part[g][k] = '0;
            end
        end

        // first level: or within a group
        always_comb begin
            n_grp[g] = '0;
            for (int k = 0; k < TREE_GRP; k++) n_grp[g] = n_grp[g] | part[g][k];
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp <= n_grp;
    end

    // second level: or across groups
    always_comb begin
        sum = '0;
        for (int g = 0; g < NGRP; g++) sum = sum | r_grp[g];
    end

    assign o_word = sum;

endmodule

FILE: design/indexed_shift_list.sv
// ----------------------------------------------------------------------------
// indexed_shift_list
// fixed-capacity ordered word list held in a chain of shifting cells
// ----------------------------------------------------------------------------
// channel   | ports                      | transfer
// ----------+----------------------------+----------------------------------
// command   | start, busy, i_cmd         | edge with start high, busy low
// result    | o_valid, o_result          | edge ending the o_valid cycle
//
// From a command's transfer to the earliest next one, the cells execute and
// register the selected tap, the or tree registers its group results, the
// result is registered, then it is shown for one cycle.
// o_valid is high in the cycle busy drops, so the next command may start then.
// Reset clears the fill count and control; cell words are not reset.
// Results cannot be stalled; each is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module indexed_shift_list import isl_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_cmd,
    output logic o_valid,
    output t_out o_result
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXEC   = 4'b0010,
        S_GATHER = 4'b0100,
        S_OUT    = 4'b1000
    } t_state;

    t_state           r_state;
    t_state           n_state;
    t_in              r_cmd;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [1:0]       r_status;
    logic [1:0]       n_status;
    logic             r_bad_read;
    logic             n_bad_read;
    logic             r_valid;
    t_out             r_result;

    t_cell_ctl        n_ctl;
    logic [IDX_W-1:0] n_pos;
    logic [IDX_W-1:0] n_sel;

    logic [CMP_W-1:0] cnt_x;
    logic [CMP_W-1:0] idx_x;
    logic [CMP_W-1:0] cnt_m1_x;
    logic             full;
    logic             empty;
    logic             accept;

    t_word words [CAPACITY];
    t_word taps  [CAPACITY];
    t_word tree_word;

    assign accept   = start && (r_state == S_IDLE);
    assign cnt_x    = CMP_W'(r_count);
    assign idx_x    = CMP_W'(r_cmd.index);
    assign cnt_m1_x = cnt_x - CMP_W'(1);
    assign full     = (r_count == CNT_W'(CAPACITY));
    assign empty    = (r_count == '0);

    // decode the command against the current fill count
    always_comb begin
        n_count    = r_count;
        n_status   = ST_OK;
        n_bad_read = 1'b0;
        n_ctl.op   = CELL_HOLD;
        n_ctl.tap_en = 1'b0;
        n_pos      = idx_x[IDX_W-1:0];
        n_sel      = idx_x[IDX_W-1:0];
        case (r_cmd.func)
            FUNC_READ: begin
                if (idx_x < cnt_x) begin
                    n_ctl.tap_en = 1'b1;
                end else begin
                    n_status   = ST_RANGE;
                    n_bad_read = 1'b1;
                end
            end
            FUNC_WRITE: begin
                if (idx_x < cnt_x) n_ctl.op = CELL_WRITE;
                else n_status = ST_RANGE;
            end
            FUNC_PUSH_BACK: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_ctl.op = CELL_INS;
                    n_pos    = cnt_x[IDX_W-1:0];
                    n_count  = r_count + CNT_W'(1);
                end
            end
            FUNC_PUSH_FRONT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_ctl.op = CELL_INS;
                    n_pos    = '0;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            FUNC_POP_BACK: begin
                if (empty) n_status = ST_EMPTY;
                else n_count = r_count - CNT_W'(1);
            end
            FUNC_POP_FRONT: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_ctl.op = CELL_DEL;
                    n_pos    = '0;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            FUNC_INSERT: begin
                if (idx_x > cnt_x) begin
                    n_status = ST_RANGE;
                end else if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_ctl.op = CELL_INS;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            FUNC_REMOVE: begin
                if (idx_x >= cnt_x) begin
                    n_status = ST_RANGE;
                end else begin
                    n_ctl.op = CELL_DEL;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            FUNC_CLEAR: begin
                n_count = '0;
            end
            FUNC_FRONT: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_ctl.tap_en = 1'b1;
                    n_sel        = '0;
                end
            end
            FUNC_BACK: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_ctl.tap_en = 1'b1;
                    n_sel        = cnt_m1_x[IDX_W-1:0];
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
        // cells act only in the execute cycle
        if (r_state != S_EXEC) begin
            n_ctl.op     = CELL_HOLD;
            n_ctl.tap_en = 1'b0;
        end
    end

    // sequencer
    always_comb begin
        case (r_state)
            S_IDLE:   n_state = accept ? S_EXEC : S_IDLE;
            S_EXEC:   n_state = S_GATHER;
            S_GATHER: n_state = S_OUT;
            S_OUT:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_OUT);
            if (r_state == S_EXEC) r_count <= n_count;
        end
    end

    // command capture and per-command result fields
    always_ff @(posedge i_clk) begin
        if (accept) r_cmd <= i_cmd;
        if (r_state == S_EXEC) begin
            r_status   <= n_status;
            r_bad_read <= n_bad_read;
        end
        if (r_state == S_OUT) begin
            r_result.data   <= r_bad_read ? BAD_READ_WORD : tree_word;
            r_result.count  <= cnt_x[6:0];
            r_result.status <= r_status;
        end
    end

    // chain of cells
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        t_word prev_word;
        t_word next_word;

        if (i == 0) begin : g_first
            assign prev_word = '0;
        end else begin : g_mid_l
            assign prev_word = words[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign next_word = '0;
        end else begin : g_mid_r
            assign next_word = words[i+1];
        end

        isl_cell #(
            .IDX_W    (IDX_W),
            .CELL_POS (i)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (n_ctl),
            .i_pos   (n_pos),
            .i_sel   (n_sel),
            .i_value (r_cmd.value),
            .i_prev  (prev_word),
            .i_next  (next_word),
            .o_word  (words[i]),
            .o_tap   (taps[i])
        );
    end

    // read-out of the selected tap
    isl_or_tree #(
        .CAPACITY (CAPACITY)
    ) u_tree (
        .i_clk  (i_clk),
        .i_taps (taps),
        .o_word (tree_word)
    );

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

FILE: design/isl_checker.sv
// ----------------------------------------------------------------------------
// isl_checker
// port-level timing checks for the indexed shift list
// ----------------------------------------------------------------------------
`include "indexed_shift_list_assert.svh"

module isl_checker import isl_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic i_busy,
    input logic i_valid,
    input t_out i_result
);

    // an accepted command makes the block busy
    `ISL_ASSERT_NEXT(a_accept_busy, i_start && !i_busy, i_busy)

    // every command yields its result after the execute, gather and output states
    `ISL_ASSERT_SAME(a_result_latency, $rose(i_busy), ##3 i_valid)

    // a result is shown while the block is free again
    `ISL_ASSERT_SAME(a_valid_idle, i_valid, !i_busy)

    // an empty report always comes with an empty list
    `ISL_ASSERT_SAME(a_empty_count, i_valid && (i_result.status == ST_EMPTY),
                     i_result.count == 7'd0)

endmodule

bind indexed_shift_list isl_checker u_isl_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (start),
    .i_busy   (busy),
    .i_valid  (o_valid),
    .i_result (o_result)
);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for indexed_shift_list: a command driver fed from a
// queue, an in-order result monitor and a behavioral list predictor
// ----------------------------------------------------------------------------
// Directed commands cover the empty and out-of-range corners. Random
// commands then run in chunks that grow, shrink or mix the list, with random
// gaps between transfers. Every result is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
    import isl_pkg::*;

    localparam int LIST_CAP    = 64;
    localparam int RAND_ITEMS  = 500;
    localparam int CHUNK_ITEMS = 10;
    localparam int STALL_LIMIT = 1000;
    localparam int TAIL_CYCLES = 8;
    localparam int PRINT_CAP   = 40;

    typedef enum int {
        MODE_GROW,
        MODE_SHRINK,
        MODE_MIX
    } t_mode;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_in  i_cmd   = '0;
    logic busy;
    logic o_valid;
    t_out o_result;

    // commands waiting for the driver, results waiting for the monitor
    t_in  cmd_q[$];
    t_out result_q[$];

    // predictor state
    t_word list_mem[LIST_CAP];
    int    list_len = 0;

    int n_queued     = 0;
    int n_accepted   = 0;
    int fail_count   = 0;
    int gap_left     = 0;
    int gap_max      = 4;
    int stall_cycles = 0;

    indexed_shift_list #(
        .CAPACITY(LIST_CAP)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // list behavior for one command, updates the predictor state
    function automatic t_out list_apply(input t_in cmd);
        t_out res;
        int   pos;
        int   k;
        res        = '0;
        res.status = ST_OK;
        case (cmd.func)
            FUNC_READ: begin
                if (int'(cmd.index) < list_len) begin
                    res.data = list_mem[cmd.index];
                end else begin
                    res.data   = BAD_READ_WORD;
                    res.status = ST_RANGE;
                end
            end
            FUNC_WRITE: begin
                if (int'(cmd.index) < list_len) begin
                    list_mem[cmd.index] = cmd.value;
                end else begin
                    res.status = ST_RANGE;
                end
            end
            FUNC_PUSH_BACK, FUNC_PUSH_FRONT, FUNC_INSERT: begin
                if (cmd.func == FUNC_PUSH_BACK) begin
                    pos = list_len;
                end else if (cmd.func == FUNC_PUSH_FRONT) begin
                    pos = 0;
                end else begin
                    pos = int'(cmd.index);
                end
                // position check comes before the full check
                if (pos > list_len) begin
                    res.status = ST_RANGE;
                end else if (list_len >= LIST_CAP) begin
                    res.status = ST_FULL;
                end else begin
                    for (k = list_len; k > pos; k--) begin
                        list_mem[k] = list_mem[k - 1];
                    end
                    list_mem[pos] = cmd.value;
                    list_len++;
                end
            end
            FUNC_POP_BACK: begin
                if (list_len == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    list_len--;
                end
            end
            FUNC_POP_FRONT, FUNC_REMOVE: begin
                pos = (cmd.func == FUNC_POP_FRONT) ? 0 : int'(cmd.index);
                if (cmd.func == FUNC_POP_FRONT && list_len == 0) begin
                    res.status = ST_EMPTY;
                end else if (pos >= list_len) begin
                    res.status = ST_RANGE;
                end else begin
                    for (k = pos; k + 1 < list_len; k++) begin
                        list_mem[k] = list_mem[k + 1];
                    end
                    list_len--;
                end
            end
            FUNC_CLEAR: begin
                for (k = 0; k < LIST_CAP; k++) begin
                    list_mem[k] = '0;
                end
                list_len = 0;
            end
            FUNC_FRONT: begin
                if (list_len == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.data = list_mem[0];
                end
            end
            FUNC_BACK: begin
                if (list_len == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.data = list_mem[list_len - 1];
                end
            end
            default: begin
            end
        endcase
        res.count = list_len[6:0];
        return res;
    endfunction

    task automatic queue_cmd(input logic [3:0] func, input logic [6:0] index,
                             input t_word value);
        t_in cmd;
        cmd.func  = func;
        cmd.index = index;
        cmd.value = value;
        cmd_q.push_back(cmd);
        n_queued++;
    endtask

    // command driver, predicts at each transfer
    always @(posedge i_clk) begin
        int draw;
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left <= 0;
        end else if (start && !busy) begin
            result_q.push_back(list_apply(i_cmd));
            n_accepted++;
            draw = $urandom_range(0, gap_max);
            if (draw == 0 && cmd_q.size() > 0) begin
                i_cmd <= cmd_q.pop_front();
            end else begin
                start    <= 1'b0;
                gap_left <= draw;
            end
        end else if (!start) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (cmd_q.size() > 0) begin
                start <= 1'b1;
                i_cmd <= cmd_q.pop_front();
            end
        end
    end

    // result monitor, in-order compare
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid) begin
            if (result_q.size() == 0) begin
                fail_count++;
                if (fail_count < PRINT_CAP) begin
                    $display("%0t: unexpected result, expected none, got data %0d count %0d status %0d",
                             $time, o_result.data, o_result.count, o_result.status);
                end
            end else begin
                want = result_q.pop_front();
                if (o_result.data !== want.data) begin
                    fail_count++;
                    if (fail_count < PRINT_CAP) begin
                        $display("%0t: data mismatch, expected %0d, got %0d",
                                 $time, want.data, o_result.data);
                    end
                end
                if (o_result.count !== want.count) begin
                    fail_count++;
                    if (fail_count < PRINT_CAP) begin
                        $display("%0t: count mismatch, expected %0d, got %0d",
                                 $time, want.count, o_result.count);
                    end
                end
                if (o_result.status !== want.status) begin
                    fail_count++;
                    if (fail_count < PRINT_CAP) begin
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, o_result.status);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // stimulus and end of run
    initial begin
        t_mode      mode;
        int         rand_done;
        int         n;
        int         r;
        logic [3:0] func;
        logic [6:0] index;
        t_word      value;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty list corners
        queue_cmd(FUNC_READ, 7'd0, 32'sd0);
        queue_cmd(FUNC_READ, 7'd127, 32'sd0);
        queue_cmd(FUNC_WRITE, 7'd0, 32'sd5);
        queue_cmd(FUNC_POP_BACK, 7'd0, 32'sd0);
        queue_cmd(FUNC_POP_FRONT, 7'd0, 32'sd0);
        queue_cmd(FUNC_FRONT, 7'd0, 32'sd0);
        queue_cmd(FUNC_BACK, 7'd0, 32'sd0);
        queue_cmd(FUNC_REMOVE, 7'd0, 32'sd0);
        queue_cmd(FUNC_INSERT, 7'd1, 32'sd9);
        // build a short list with extreme words
        queue_cmd(FUNC_INSERT, 7'd0, 32'h8000_0000);
        queue_cmd(FUNC_PUSH_BACK, 7'd127, 32'h7fff_ffff);
        queue_cmd(FUNC_PUSH_FRONT, 7'd0, 32'hffff_ffff);
        queue_cmd(FUNC_INSERT, 7'd2, 32'h5555_aaaa);
        queue_cmd(FUNC_READ, 7'd0, 32'sd0);
        queue_cmd(FUNC_READ, 7'd3, 32'sd0);
        queue_cmd(FUNC_READ, 7'd4, 32'sd0);
        queue_cmd(FUNC_WRITE, 7'd3, 32'haaaa_5555);
        queue_cmd(FUNC_WRITE, 7'd4, 32'sd1);
        queue_cmd(FUNC_FRONT, 7'd0, 32'sd0);
        queue_cmd(FUNC_BACK, 7'd0, 32'sd0);
        queue_cmd(FUNC_REMOVE, 7'd1, 32'sd0);
        queue_cmd(FUNC_POP_FRONT, 7'd0, 32'sd0);
        queue_cmd(FUNC_POP_BACK, 7'd0, 32'sd0);
        // unused selectors leave the list alone
        queue_cmd(4'd11, 7'd127, 32'hffff_ffff);
        queue_cmd(4'd15, 7'd0, 32'sd0);
        queue_cmd(FUNC_CLEAR, 7'd0, 32'sd0);

        // random chunks, each generated against the list length so far
        mode      = MODE_GROW;
        rand_done = 0;
        while (rand_done < RAND_ITEMS) begin
            while (n_accepted != n_queued) @(posedge i_clk);

            if (list_len == 0) begin
                mode = MODE_GROW;
            end else if (list_len >= LIST_CAP && $urandom_range(0, 1) == 0) begin
                mode = MODE_SHRINK;
            end else if (mode == MODE_SHRINK && list_len < 4) begin
                mode = MODE_GROW;
            end else if ($urandom_range(0, 4) == 0) begin
                mode = MODE_MIX;
            end else if (mode == MODE_MIX) begin
                mode = ($urandom_range(0, 1) == 0) ? MODE_GROW : MODE_SHRINK;
            end
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : 4;

            for (n = 0; n < CHUNK_ITEMS; n++) begin
                // operation
                r = $urandom_range(0, 99);
                if (mode == MODE_MIX || r >= 85) begin
                    func = 4'($urandom_range(0, 15));
                    if (func == FUNC_CLEAR &&
                        (mode != MODE_MIX || $urandom_range(0, 3) != 0)) begin
                        func = FUNC_READ;
                    end
                end else if (r < 70) begin
                    if (mode == MODE_GROW) begin
                        func = (r < 25) ? FUNC_PUSH_BACK :
                               (r < 45) ? FUNC_PUSH_FRONT : FUNC_INSERT;
                    end else begin
                        func = (r < 25) ? FUNC_POP_BACK :
                               (r < 45) ? FUNC_POP_FRONT : FUNC_REMOVE;
                    end
                end else begin
                    func = (r < 80) ? FUNC_READ : FUNC_WRITE;
                end

                // position, mostly near the live range
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    index = 7'($urandom_range(0, list_len));
                end else if (r < 85) begin
                    index = 7'($urandom_range(0, 127));
                end else begin
                    case ($urandom_range(0, 3))
                        0:       index = 7'd0;
                        1:       index = (list_len > 0) ? 7'(list_len - 1) : 7'd0;
                        2:       index = 7'(list_len);
                        default: index = 7'd127;
                    endcase
                end

                // word, with some extremes
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    case ($urandom_range(0, 3))
                        0:       value = 32'h8000_0000;
                        1:       value = 32'h7fff_ffff;
                        2:       value = 32'hffff_ffff;
                        default: value = 32'h0000_0000;
                    endcase
                end else begin
                    value = t_word'($urandom);
                end

                queue_cmd(func, index, value);
                if (func <= FUNC_BACK) begin
                    rand_done++;
                end
            end
        end

        // drain
        while (n_accepted != n_queued) @(posedge i_clk);
        while (result_q.size() > 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
